[rtl/prmts_pkg.sv]
`default_nettype none

package prmts_pkg;

   // Data widths.
   localparam int SAMPLE_W = 24;
   localparam int INT_W    = 28;
   localparam int COEF_W   = 16;
   localparam int ACC_W    = 31;
   localparam int ADDR_W   = 14;
   localparam int LEN_W    = 13;
   localparam int STEP_W   = 7;
   localparam int EXC_W    = 6;
   localparam int T_W      = 16;
   localparam int CSR_IDX_W = 3;

   // Microprogram length and clearing pass.
   localparam logic [STEP_W-1:0] LAST_STEP = 7'd99;
   localparam logic [ADDR_W-1:0] CLEAR_LAST = 14'h3fff;

   // Pre-delay limit and tank gain limits.
   localparam logic [LEN_W-1:0]  PRE_DELAY_MAX = 13'd4800;
   localparam logic [COEF_W:0]   DD2_OFFSET    = 17'd9830;
   localparam logic [COEF_W:0]   DD2_LOW       = 17'd16384;
   localparam logic [COEF_W:0]   DD2_HIGH      = 17'd32768;
   localparam logic [10:0]       MOD_PERIOD_MASK = 11'h7ff;
   localparam logic [EXC_W-1:0]  EXC_MAX       = 6'd63;

   // Memory depths that are not powers of two.
   localparam logic [ADDR_W-1:0] DIF_DEPTH = 14'd1408;
   localparam logic [ADDR_W-1:0] AP2_DEPTH = 14'd6144;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_DELAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_COEF  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_DIFF1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_DIFF2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_DIFF1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP      = 3'd6;

   // Register reset values.
   localparam logic [LEN_W-1:0]  RST_PRE_DELAY = 13'd480;
   localparam logic [COEF_W-1:0] RST_PRE_COEF  = 16'd55706;
   localparam logic [COEF_W-1:0] RST_IN_DIFF1  = 16'd49152;
   localparam logic [COEF_W-1:0] RST_IN_DIFF2  = 16'd40960;
   localparam logic [COEF_W-1:0] RST_DECAY     = 16'd49152;
   localparam logic [COEF_W-1:0] RST_DEC_DIFF1 = 16'd45875;
   localparam logic [COEF_W-1:0] RST_DAMP      = 16'd62259;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_type;

   typedef enum logic [2:0] {M_NONE, M_PD, M_DIF, M_AP1, M_PRE, M_AP2, M_POST} mem_type;

   typedef enum logic [1:0] {LM_FIX, LM_EXC, LM_PD} lmode_type;

   typedef enum logic [2:0] {C_PRE, C_ID1, C_ID2, C_DECAY, C_DD1, C_DAMP, C_DD2} coef_type;

   typedef enum logic [4:0] {
      A_NOP, A_LDX, A_LDD, A_MUL_D, A_MUL_V, A_MUL_X,
      A_V_X_MINUS_LPI, A_V_X_MINUS_LPD, A_LPI_ADD, A_LPD_ADD,
      A_V_X_MINUS_P, A_V_X_PLUS_P, A_X_D_PLUS_P, A_X_D_MINUS_P, A_X_XS_PLUS_P,
      A_X_P, A_SAVE, A_EXC, A_TINC, A_ACC_CLR, A_ACC_ADD, A_ACC_SUB, A_OUT_L, A_OUT_R
   } alu_type;

   // One microinstruction: a memory access and an arithmetic operation.
   typedef struct packed {
      mem_type            mem;
      logic               wr;
      logic [ADDR_W-1:0]  base;
      logic [ADDR_W-1:0]  mask;
      logic [LEN_W-1:0]   len;
      lmode_type          lmode;
      alu_type            alu;
      coef_type           coef;
      logic               half;
   } uop_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic               clear;
      logic [ADDR_W-1:0]  clear_addr;
      logic               load;
      logic               exec;
      logic [STEP_W-1:0]  step;
   } cmd_type;

   function automatic uop_type uop_make(mem_type m, logic w, int b, int k, int l, lmode_type lm,
                                        alu_type a, coef_type c, logic h);
      uop_type u;
      u.mem   = m;
      u.wr    = w;
      u.base  = ADDR_W'(b);
      u.mask  = ADDR_W'(k);
      u.len   = LEN_W'(l);
      u.lmode = lm;
      u.alu   = a;
      u.coef  = c;
      u.half  = h;
      return u;
   endfunction

   function automatic uop_type uop_op(alu_type a, coef_type c, logic h);
      return uop_make(M_NONE, 1'b0, 0, 0, 0, LM_FIX, a, c, h);
   endfunction

   function automatic uop_type uop_rd(mem_type m, int b, int k, int l, lmode_type lm,
                                      alu_type a);
      return uop_make(m, 1'b0, b, k, l, lm, a, C_PRE, 1'b0);
   endfunction

   function automatic uop_type uop_wr(mem_type m, int b, int k, alu_type a, coef_type c);
      return uop_make(m, 1'b1, b, k, 0, LM_FIX, a, c, 1'b0);
   endfunction

   // Microprogram for one item.
   function automatic uop_type uop_rom(logic [STEP_W-1:0] s);
      uop_type u;
      case (s)
         // Pre-delay and input lowpass.
         7'd0:  u = uop_wr(M_PD, 0, 8191, A_EXC, C_PRE);
         7'd1:  u = uop_rd(M_PD, 0, 8191, 0, LM_PD, A_NOP);
         7'd2:  u = uop_op(A_LDX, C_PRE, 1'b0);
         7'd3:  u = uop_op(A_V_X_MINUS_LPI, C_PRE, 1'b0);
         7'd4:  u = uop_op(A_MUL_V, C_PRE, 1'b0);
         7'd5:  u = uop_op(A_LPI_ADD, C_PRE, 1'b0);
         // Input diffuser one.
         7'd6:  u = uop_rd(M_DIF, 0, 255, 142, LM_FIX, A_NOP);
         7'd7:  u = uop_op(A_LDD, C_ID1, 1'b0);
         7'd8:  u = uop_op(A_MUL_D, C_ID1, 1'b0);
         7'd9:  u = uop_op(A_V_X_MINUS_P, C_ID1, 1'b0);
         7'd10: u = uop_wr(M_DIF, 0, 255, A_MUL_V, C_ID1);
         7'd11: u = uop_op(A_X_D_PLUS_P, C_ID1, 1'b0);
         // Input diffuser two.
         7'd12: u = uop_rd(M_DIF, 256, 127, 107, LM_FIX, A_NOP);
         7'd13: u = uop_op(A_LDD, C_ID1, 1'b0);
         7'd14: u = uop_op(A_MUL_D, C_ID1, 1'b0);
         7'd15: u = uop_op(A_V_X_MINUS_P, C_ID1, 1'b0);
         7'd16: u = uop_wr(M_DIF, 256, 127, A_MUL_V, C_ID1);
         7'd17: u = uop_op(A_X_D_PLUS_P, C_ID1, 1'b0);
         // Input diffuser three.
         7'd18: u = uop_rd(M_DIF, 384, 511, 379, LM_FIX, A_NOP);
         7'd19: u = uop_op(A_LDD, C_ID2, 1'b0);
         7'd20: u = uop_op(A_MUL_D, C_ID2, 1'b0);
         7'd21: u = uop_op(A_V_X_MINUS_P, C_ID2, 1'b0);
         7'd22: u = uop_wr(M_DIF, 384, 511, A_MUL_V, C_ID2);
         7'd23: u = uop_op(A_X_D_PLUS_P, C_ID2, 1'b0);
         // Input diffuser four.
         7'd24: u = uop_rd(M_DIF, 896, 511, 277, LM_FIX, A_NOP);
         7'd25: u = uop_op(A_LDD, C_ID2, 1'b0);
         7'd26: u = uop_op(A_MUL_D, C_ID2, 1'b0);
         7'd27: u = uop_op(A_V_X_MINUS_P, C_ID2, 1'b0);
         7'd28: u = uop_wr(M_DIF, 896, 511, A_MUL_V, C_ID2);
         7'd29: u = uop_op(A_X_D_PLUS_P, C_ID2, 1'b0);
         7'd30: u = uop_op(A_SAVE, C_PRE, 1'b0);
         // Left tank half, fed from the right half's output line.
         7'd31: u = uop_rd(M_POST, 4096, 4095, 3163, LM_FIX, A_NOP);
         7'd32: u = uop_op(A_LDD, C_DECAY, 1'b0);
         7'd33: u = uop_op(A_MUL_D, C_DECAY, 1'b0);
         7'd34: u = uop_op(A_X_XS_PLUS_P, C_DECAY, 1'b0);
         7'd35: u = uop_rd(M_AP1, 0, 1023, 672, LM_EXC, A_NOP);
         7'd36: u = uop_op(A_LDD, C_DD1, 1'b0);
         7'd37: u = uop_op(A_MUL_D, C_DD1, 1'b0);
         7'd38: u = uop_op(A_V_X_PLUS_P, C_DD1, 1'b0);
         7'd39: u = uop_wr(M_AP1, 0, 1023, A_MUL_V, C_DD1);
         7'd40: u = uop_op(A_X_D_MINUS_P, C_DD1, 1'b0);
         7'd41: u = uop_wr(M_PRE, 0, 8191, A_NOP, C_PRE);
         7'd42: u = uop_rd(M_PRE, 0, 8191, 4453, LM_FIX, A_NOP);
         7'd43: u = uop_op(A_LDX, C_PRE, 1'b0);
         7'd44: u = uop_op(A_V_X_MINUS_LPD, C_DAMP, 1'b0);
         7'd45: u = uop_op(A_MUL_V, C_DAMP, 1'b0);
         7'd46: u = uop_op(A_LPD_ADD, C_DAMP, 1'b0);
         7'd47: u = uop_op(A_MUL_X, C_DECAY, 1'b0);
         7'd48: u = uop_op(A_X_P, C_DECAY, 1'b0);
         7'd49: u = uop_rd(M_AP2, 0, 2047, 1800, LM_FIX, A_NOP);
         7'd50: u = uop_op(A_LDD, C_DD2, 1'b0);
         7'd51: u = uop_op(A_MUL_D, C_DD2, 1'b0);
         7'd52: u = uop_op(A_V_X_MINUS_P, C_DD2, 1'b0);
         7'd53: u = uop_wr(M_AP2, 0, 2047, A_MUL_V, C_DD2);
         7'd54: u = uop_op(A_X_D_PLUS_P, C_DD2, 1'b0);
         7'd55: u = uop_wr(M_POST, 0, 4095, A_NOP, C_PRE);
         // Right tank half, fed from the left half's output line.
         7'd56: u = uop_rd(M_POST, 0, 4095, 3720, LM_FIX, A_NOP);
         7'd57: u = uop_op(A_LDD, C_DECAY, 1'b1);
         7'd58: u = uop_op(A_MUL_D, C_DECAY, 1'b1);
         7'd59: u = uop_op(A_X_XS_PLUS_P, C_DECAY, 1'b1);
         7'd60: u = uop_rd(M_AP1, 1024, 1023, 908, LM_EXC, A_NOP);
         7'd61: u = uop_op(A_LDD, C_DD1, 1'b1);
         7'd62: u = uop_op(A_MUL_D, C_DD1, 1'b1);
         7'd63: u = uop_op(A_V_X_PLUS_P, C_DD1, 1'b1);
         7'd64: u = uop_wr(M_AP1, 1024, 1023, A_MUL_V, C_DD1);
         7'd65: u = uop_op(A_X_D_MINUS_P, C_DD1, 1'b1);
         7'd66: u = uop_wr(M_PRE, 8192, 8191, A_NOP, C_PRE);
         7'd67: u = uop_rd(M_PRE, 8192, 8191, 4217, LM_FIX, A_NOP);
         7'd68: u = uop_op(A_LDX, C_PRE, 1'b1);
         7'd69: u = uop_op(A_V_X_MINUS_LPD, C_DAMP, 1'b1);
         7'd70: u = uop_op(A_MUL_V, C_DAMP, 1'b1);
         7'd71: u = uop_op(A_LPD_ADD, C_DAMP, 1'b1);
         7'd72: u = uop_op(A_MUL_X, C_DECAY, 1'b1);
         7'd73: u = uop_op(A_X_P, C_DECAY, 1'b1);
         7'd74: u = uop_rd(M_AP2, 2048, 4095, 2656, LM_FIX, A_NOP);
         7'd75: u = uop_op(A_LDD, C_DD2, 1'b1);
         7'd76: u = uop_op(A_MUL_D, C_DD2, 1'b1);
         7'd77: u = uop_op(A_V_X_MINUS_P, C_DD2, 1'b1);
         7'd78: u = uop_wr(M_AP2, 2048, 4095, A_MUL_V, C_DD2);
         7'd79: u = uop_op(A_X_D_PLUS_P, C_DD2, 1'b1);
         7'd80: u = uop_wr(M_POST, 4096, 4095, A_NOP, C_PRE);
         7'd81: u = uop_op(A_TINC, C_PRE, 1'b0);
         // Left output taps.
         7'd82: u = uop_rd(M_PRE, 8192, 8191, 266, LM_FIX, A_ACC_CLR);
         7'd83: u = uop_rd(M_PRE, 8192, 8191, 2974, LM_FIX, A_ACC_ADD);
         7'd84: u = uop_rd(M_AP2, 2048, 4095, 1913, LM_FIX, A_ACC_ADD);
         7'd85: u = uop_rd(M_POST, 4096, 4095, 1996, LM_FIX, A_ACC_SUB);
         7'd86: u = uop_rd(M_PRE, 0, 8191, 1990, LM_FIX, A_ACC_ADD);
         7'd87: u = uop_rd(M_AP2, 0, 2047, 187, LM_FIX, A_ACC_SUB);
         7'd88: u = uop_rd(M_POST, 0, 4095, 1066, LM_FIX, A_ACC_SUB);
         7'd89: u = uop_op(A_ACC_ADD, C_PRE, 1'b0);
         7'd90: u = uop_op(A_OUT_L, C_PRE, 1'b0);
         // Right output taps.
         7'd91: u = uop_rd(M_PRE, 0, 8191, 353, LM_FIX, A_ACC_CLR);
         7'd92: u = uop_rd(M_PRE, 0, 8191, 3627, LM_FIX, A_ACC_ADD);
         7'd93: u = uop_rd(M_AP2, 0, 2047, 1228, LM_FIX, A_ACC_ADD);
         7'd94: u = uop_rd(M_POST, 0, 4095, 2673, LM_FIX, A_ACC_SUB);
         7'd95: u = uop_rd(M_PRE, 8192, 8191, 2111, LM_FIX, A_ACC_ADD);
         7'd96: u = uop_rd(M_AP2, 2048, 4095, 335, LM_FIX, A_ACC_SUB);
         7'd97: u = uop_rd(M_POST, 4096, 4095, 121, LM_FIX, A_ACC_SUB);
         7'd98: u = uop_op(A_ACC_ADD, C_PRE, 1'b0);
         7'd99: u = uop_op(A_OUT_R, C_PRE, 1'b0);
         default: u = uop_op(A_NOP, C_PRE, 1'b0);
      endcase
      return u;
   endfunction

   // Saturate a 29-bit sum to the internal range.
   function automatic logic signed [INT_W-1:0] sat_int(logic signed [INT_W:0] s);
      logic signed [INT_W-1:0] r;
      if (s[INT_W] != s[INT_W-1]) begin
         r = s[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end else begin
         r = s[INT_W-1:0];
      end
      return r;
   endfunction

   // Saturate the tap sum to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat_out(logic signed [ACC_W-1:0] s);
      logic signed [SAMPLE_W-1:0] r;
      if (s[ACC_W-1:SAMPLE_W-1] != {(ACC_W-SAMPLE_W+1){s[SAMPLE_W-1]}}) begin
         r = s[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         r = s[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Value times unsigned Q0.16 coefficient, rounded half up.
   function automatic logic signed [INT_W-1:0] mul_coef(logic signed [INT_W-1:0] a,
                                                        logic [COEF_W-1:0] c);
      logic signed [INT_W+COEF_W:0] prod;
      prod = (INT_W+COEF_W+1)'(a) * (INT_W+COEF_W+1)'($signed({1'b0, c}));
      prod = prod + (INT_W+COEF_W+1)'(1 << (COEF_W-1));
      return prod[INT_W+COEF_W-1:COEF_W];
   endfunction

endpackage

`default_nettype wire

[rtl/prmts_ctrl.sv]
`default_nettype none

module prmts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output prmts_pkg::cmd_type        cmd
);

   prmts_pkg::state_type                 state_ff, state_in;
   logic [prmts_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [prmts_pkg::ADDR_W-1:0]         clr_ff, clr_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 last_step;
   logic                                 stall;
   logic                                 publish;

   // The final step waits while the previous item still sits in the output register.
   assign last_step = (step_ff == prmts_pkg::LAST_STEP);
   assign stall     = (state_ff == prmts_pkg::ST_RUN) && last_step && rsp_valid_ff && !rsp_ready;
   assign publish   = (state_ff == prmts_pkg::ST_RUN) && last_step && !stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prmts_pkg::ST_CLEAR: begin
            if (clr_ff == prmts_pkg::CLEAR_LAST) state_in = prmts_pkg::ST_IDLE;
         end
         prmts_pkg::ST_IDLE: begin
            if (req_valid) state_in = prmts_pkg::ST_RUN;
         end
         prmts_pkg::ST_RUN: begin
            if (publish) state_in = prmts_pkg::ST_IDLE;
         end
         default: state_in = prmts_pkg::ST_CLEAR;
      endcase
   end

   // Step and clearing counters, result valid.
   always_comb begin
      step_in = step_ff;
      if (state_ff != prmts_pkg::ST_RUN || publish) begin
         step_in = '0;
      end else if (!stall) begin
         step_in = step_ff + prmts_pkg::STEP_W'(1);
      end
      clr_in = (state_ff == prmts_pkg::ST_CLEAR) ? clr_ff + prmts_pkg::ADDR_W'(1) : clr_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Outputs.
   always_comb begin
      req_ready      = (state_ff == prmts_pkg::ST_IDLE);
      rsp_valid      = rsp_valid_ff;
      cmd.clear      = (state_ff == prmts_pkg::ST_CLEAR);
      cmd.clear_addr = clr_ff;
      cmd.load       = (state_ff == prmts_pkg::ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == prmts_pkg::ST_RUN) && !stall;
      cmd.step       = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prmts_pkg::ST_CLEAR;
         step_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/prmts_datapath.sv]
`default_nettype none

module prmts_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire prmts_pkg::cmd_type                     cmd,
   input  wire logic signed [prmts_pkg::SAMPLE_W-1:0]  sample_in,
   input  wire logic                                   csr_we,
   input  wire logic [prmts_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [prmts_pkg::COEF_W-1:0]           csr_data,
   output logic signed [prmts_pkg::SAMPLE_W-1:0]       left_out,
   output logic signed [prmts_pkg::SAMPLE_W-1:0]       right_out
);

   localparam int IW = prmts_pkg::INT_W;
   localparam int CW = prmts_pkg::COEF_W;
   localparam int AW = prmts_pkg::ADDR_W;

   prmts_pkg::uop_type uop;

   // Configuration registers.
   logic [prmts_pkg::LEN_W-1:0] pre_delay_ff;
   logic [CW-1:0] pre_coef_ff, in_diff1_ff, in_diff2_ff, decay_ff, dec_diff1_ff, damp_ff;

   // Working registers.
   logic signed [IW-1:0] x_ff, x_in, d_ff, d_in, v_ff, v_in, p_ff, p_in, xs_ff, xs_in;
   logic signed [IW-1:0] lpi_ff, lpi_in;
   logic signed [IW-1:0] lpd_ff [2];
   logic signed [IW-1:0] lpd_in [2];
   logic signed [prmts_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [prmts_pkg::SAMPLE_W-1:0] left_stage_ff, left_stage_in;
   logic signed [prmts_pkg::SAMPLE_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [prmts_pkg::T_W-1:0]   t_ff, t_in;
   logic [prmts_pkg::EXC_W-1:0] exc_ff, exc_in;
   prmts_pkg::mem_type          rsel_ff;

   // Delay stores.
   logic signed [IW-1:0] pd_mem   [8192];
   logic signed [IW-1:0] dif_mem  [1408];
   logic signed [IW-1:0] ap1_mem  [2048];
   logic signed [IW-1:0] pre_mem  [16384];
   logic signed [IW-1:0] ap2_mem  [6144];
   logic signed [IW-1:0] post_mem [8192];
   logic signed [IW-1:0] pd_q_ff, dif_q_ff, ap1_q_ff, pre_q_ff, ap2_q_ff, post_q_ff;

   logic [prmts_pkg::LEN_W-1:0] pd_clamp;
   logic [CW:0]                 dd2_sum;
   logic [CW-1:0]               dd2;
   logic [CW-1:0]               coef;
   logic [AW-1:0]               len_eff, offset, addr, waddr;
   logic signed [IW-1:0]        q, wdata, mwdata, mul_a, mul_r;
   logic signed [IW-1:0]        add_a, add_b;
   logic                        add_sub;
   logic signed [IW-1:0]        add_r;
   logic signed [prmts_pkg::ACC_W-1:0] q_ext;
   logic                        op_we;
   logic pd_we, dif_we, ap1_we, pre_we, ap2_we, post_we;

   assign uop = prmts_pkg::uop_rom(cmd.step);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_delay_ff <= prmts_pkg::RST_PRE_DELAY;
         pre_coef_ff  <= prmts_pkg::RST_PRE_COEF;
         in_diff1_ff  <= prmts_pkg::RST_IN_DIFF1;
         in_diff2_ff  <= prmts_pkg::RST_IN_DIFF2;
         decay_ff     <= prmts_pkg::RST_DECAY;
         dec_diff1_ff <= prmts_pkg::RST_DEC_DIFF1;
         damp_ff      <= prmts_pkg::RST_DAMP;
      end else if (csr_we) begin
         case (csr_index)
            prmts_pkg::CSR_PRE_DELAY: pre_delay_ff <= csr_data[prmts_pkg::LEN_W-1:0];
            prmts_pkg::CSR_PRE_COEF:  pre_coef_ff  <= csr_data;
            prmts_pkg::CSR_IN_DIFF1:  in_diff1_ff  <= csr_data;
            prmts_pkg::CSR_IN_DIFF2:  in_diff2_ff  <= csr_data;
            prmts_pkg::CSR_DECAY:     decay_ff     <= csr_data;
            prmts_pkg::CSR_DEC_DIFF1: dec_diff1_ff <= csr_data;
            prmts_pkg::CSR_DAMP:      damp_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Derived values: clamped pre-delay, second tank diffusion gain and the coefficient select.
   always_comb begin
      pd_clamp = (pre_delay_ff > prmts_pkg::PRE_DELAY_MAX) ? prmts_pkg::PRE_DELAY_MAX
                                                           : pre_delay_ff;
      dd2_sum = {1'b0, decay_ff} + prmts_pkg::DD2_OFFSET;
      if (dd2_sum < prmts_pkg::DD2_LOW) begin
         dd2 = prmts_pkg::DD2_LOW[CW-1:0];
      end else if (dd2_sum > prmts_pkg::DD2_HIGH) begin
         dd2 = prmts_pkg::DD2_HIGH[CW-1:0];
      end else begin
         dd2 = dd2_sum[CW-1:0];
      end
      case (uop.coef)
         prmts_pkg::C_PRE:   coef = pre_coef_ff;
         prmts_pkg::C_ID1:   coef = in_diff1_ff;
         prmts_pkg::C_ID2:   coef = in_diff2_ff;
         prmts_pkg::C_DECAY: coef = decay_ff;
         prmts_pkg::C_DD1:   coef = dec_diff1_ff;
         prmts_pkg::C_DAMP:  coef = damp_ff;
         prmts_pkg::C_DD2:   coef = dd2;
         default:            coef = pre_coef_ff;
      endcase
   end

   // Delay line address: base plus (counter minus length) within the line; write data and enables.
   always_comb begin
      case (uop.lmode)
         prmts_pkg::LM_FIX: len_eff = AW'(uop.len);
         prmts_pkg::LM_EXC: len_eff = AW'(uop.len) + AW'(exc_ff);
         prmts_pkg::LM_PD:  len_eff = AW'(pd_clamp);
         default:           len_eff = AW'(uop.len);
      endcase
      offset = (t_ff[AW-1:0] - len_eff) & uop.mask;
      addr   = uop.base + offset;
      op_we  = cmd.exec && uop.wr;
      if (uop.mem == prmts_pkg::M_PD || uop.mem == prmts_pkg::M_PRE ||
          uop.mem == prmts_pkg::M_POST) begin
         mwdata = x_ff;
      end else begin
         mwdata = v_ff;
      end
      waddr = cmd.clear ? cmd.clear_addr : addr;
      wdata = cmd.clear ? '0 : mwdata;
      pd_we   = cmd.clear || (op_we && uop.mem == prmts_pkg::M_PD);
      dif_we  = (cmd.clear && cmd.clear_addr < prmts_pkg::DIF_DEPTH) ||
                (op_we && uop.mem == prmts_pkg::M_DIF);
      ap1_we  = cmd.clear || (op_we && uop.mem == prmts_pkg::M_AP1);
      pre_we  = cmd.clear || (op_we && uop.mem == prmts_pkg::M_PRE);
      ap2_we  = (cmd.clear && cmd.clear_addr < prmts_pkg::AP2_DEPTH) ||
                (op_we && uop.mem == prmts_pkg::M_AP2);
      post_we = cmd.clear || (op_we && uop.mem == prmts_pkg::M_POST);
   end

   // Stores: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (pd_we) pd_mem[waddr[12:0]] <= wdata;
      if (uop.mem == prmts_pkg::M_PD) pd_q_ff <= pd_mem[addr[12:0]];
   end

   always_ff @(posedge clock) begin
      if (dif_we) dif_mem[waddr[10:0]] <= wdata;
      if (uop.mem == prmts_pkg::M_DIF) dif_q_ff <= dif_mem[addr[10:0]];
   end

   always_ff @(posedge clock) begin
      if (ap1_we) ap1_mem[waddr[10:0]] <= wdata;
      if (uop.mem == prmts_pkg::M_AP1) ap1_q_ff <= ap1_mem[addr[10:0]];
   end

   always_ff @(posedge clock) begin
      if (pre_we) pre_mem[waddr] <= wdata;
      if (uop.mem == prmts_pkg::M_PRE) pre_q_ff <= pre_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (ap2_we) ap2_mem[waddr[12:0]] <= wdata;
      if (uop.mem == prmts_pkg::M_AP2) ap2_q_ff <= ap2_mem[addr[12:0]];
   end

   always_ff @(posedge clock) begin
      if (post_we) post_mem[waddr[12:0]] <= wdata;
      if (uop.mem == prmts_pkg::M_POST) post_q_ff <= post_mem[addr[12:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsel_ff <= uop.mem;
   end

   // Read data of the store that the previous step addressed.
   always_comb begin
      case (rsel_ff)
         prmts_pkg::M_PD:   q = pd_q_ff;
         prmts_pkg::M_DIF:  q = dif_q_ff;
         prmts_pkg::M_AP1:  q = ap1_q_ff;
         prmts_pkg::M_PRE:  q = pre_q_ff;
         prmts_pkg::M_AP2:  q = ap2_q_ff;
         prmts_pkg::M_POST: q = post_q_ff;
         default:           q = pre_q_ff;
      endcase
      q_ext = prmts_pkg::ACC_W'(q);
   end

   // Shared multiplier operand and saturating adder.
   always_comb begin
      case (uop.alu)
         prmts_pkg::A_MUL_D: mul_a = d_ff;
         prmts_pkg::A_MUL_X: mul_a = x_ff;
         default:            mul_a = v_ff;
      endcase
      mul_r = prmts_pkg::mul_coef(mul_a, coef);

      add_a   = x_ff;
      add_b   = p_ff;
      add_sub = 1'b0;
      case (uop.alu)
         prmts_pkg::A_V_X_MINUS_LPI: begin
            add_b = lpi_ff;
            add_sub = 1'b1;
         end
         prmts_pkg::A_V_X_MINUS_LPD: begin
            add_b = lpd_ff[uop.half];
            add_sub = 1'b1;
         end
         prmts_pkg::A_LPI_ADD:     add_a = lpi_ff;
         prmts_pkg::A_LPD_ADD:     add_a = lpd_ff[uop.half];
         prmts_pkg::A_V_X_MINUS_P: add_sub = 1'b1;
         prmts_pkg::A_X_D_PLUS_P:  add_a = d_ff;
         prmts_pkg::A_X_D_MINUS_P: begin
            add_a = d_ff;
            add_sub = 1'b1;
         end
         prmts_pkg::A_X_XS_PLUS_P: add_a = xs_ff;
         default: ;
      endcase
      add_r = prmts_pkg::sat_int(add_sub ? (IW+1)'(add_a) - (IW+1)'(add_b)
                                         : (IW+1)'(add_a) + (IW+1)'(add_b));
   end

   // Register updates for each operation.
   always_comb begin
      x_in = x_ff;
      d_in = d_ff;
      v_in = v_ff;
      p_in = p_ff;
      xs_in = xs_ff;
      lpi_in = lpi_ff;
      lpd_in = lpd_ff;
      acc_in = acc_ff;
      left_stage_in = left_stage_ff;
      left_in = left_ff;
      right_in = right_ff;
      t_in = t_ff;
      exc_in = exc_ff;
      if (cmd.load) begin
         x_in = IW'(sample_in);
      end else if (cmd.exec) begin
         case (uop.alu)
            prmts_pkg::A_LDX: x_in = q;
            prmts_pkg::A_LDD: d_in = q;
            prmts_pkg::A_MUL_D, prmts_pkg::A_MUL_V, prmts_pkg::A_MUL_X: p_in = mul_r;
            prmts_pkg::A_V_X_MINUS_LPI, prmts_pkg::A_V_X_MINUS_LPD,
            prmts_pkg::A_V_X_MINUS_P, prmts_pkg::A_V_X_PLUS_P: v_in = add_r;
            prmts_pkg::A_LPI_ADD: begin
               lpi_in = add_r;
               x_in = add_r;
            end
            prmts_pkg::A_LPD_ADD: begin
               lpd_in[uop.half] = add_r;
               x_in = add_r;
            end
            prmts_pkg::A_X_D_PLUS_P, prmts_pkg::A_X_D_MINUS_P,
            prmts_pkg::A_X_XS_PLUS_P: x_in = add_r;
            prmts_pkg::A_X_P:  x_in = p_ff;
            prmts_pkg::A_SAVE: xs_in = x_ff;
            prmts_pkg::A_EXC: begin
               // Triangle modulation: one step every 2048 items.
               if ((t_ff[10:0] & prmts_pkg::MOD_PERIOD_MASK) == '0) begin
                  if (!t_ff[prmts_pkg::T_W-1]) begin
                     if (exc_ff < prmts_pkg::EXC_MAX) exc_in = exc_ff + prmts_pkg::EXC_W'(1);
                  end else if (exc_ff != '0) begin
                     exc_in = exc_ff - prmts_pkg::EXC_W'(1);
                  end
               end
            end
            prmts_pkg::A_TINC:    t_in = t_ff + prmts_pkg::T_W'(1);
            prmts_pkg::A_ACC_CLR: acc_in = '0;
            prmts_pkg::A_ACC_ADD: acc_in = acc_ff + q_ext;
            prmts_pkg::A_ACC_SUB: acc_in = acc_ff - q_ext;
            prmts_pkg::A_OUT_L:   left_stage_in = prmts_pkg::sat_out(acc_ff);
            prmts_pkg::A_OUT_R: begin
               left_in = left_stage_ff;
               right_in = prmts_pkg::sat_out(acc_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      d_ff <= d_in;
      v_ff <= v_in;
      p_ff <= p_in;
      xs_ff <= xs_in;
      acc_ff <= acc_in;
      left_stage_ff <= left_stage_in;
      left_ff <= left_in;
      right_ff <= right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lpi_ff <= '0;
         lpd_ff[0] <= '0;
         lpd_ff[1] <= '0;
         t_ff <= '0;
         exc_ff <= '0;
      end else begin
         lpi_ff <= lpi_in;
         lpd_ff <= lpd_in;
         t_ff <= t_in;
         exc_ff <= exc_in;
      end
   end

   assign left_out  = left_ff;
   assign right_out = right_ff;

endmodule

`default_nettype wire

[rtl/plate_reverb_mono_to_stereo_core.sv]
`default_nettype none

// Plate reverb, mono in and stereo wet out, in the figure-of-eight tank form. Each item
// runs through a fixed microprogram of 100 steps, one step per clock cycle unless the last
// step stalls. The result shows on rsp_valid once the last step is done. The block takes
// the next item only once it is back in idle, so it cannot accept an item while the
// previous one is still running. The sequencer shares one multiplier, one saturating
// adder and one write port and one read port on each delay store among all the work of
// the item. After reset the block zeroes its delay stores in a clearing pass, with
// req_ready low. A finished result waits in an output register, and the next item may be
// accepted meanwhile. That item then holds at its last step until the waiting result is
// taken. Write the configuration registers only while no item is in flight.
module plate_reverb_mono_to_stereo_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [prmts_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [prmts_pkg::SAMPLE_W-1:0]       rsp_left_out,
   output logic signed [prmts_pkg::SAMPLE_W-1:0]       rsp_right_out,
   input  wire logic                                   csr_we,
   input  wire logic [prmts_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [prmts_pkg::COEF_W-1:0]           csr_data
);

   prmts_pkg::cmd_type cmd;

   // Sequencer.
   prmts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic, delay stores and configuration.
   prmts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample_in (req_sample_in),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

endmodule

`default_nettype wire

[rtl/prmts_check.sv]
`default_nettype none

module prmts_check (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [prmts_pkg::SAMPLE_W-1:0]  rsp_left_out,
   input wire logic signed [prmts_pkg::SAMPLE_W-1:0]  rsp_right_out
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("result changed while stalled");

   // One item at a time: no acceptance right after an acceptance.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // The clearing pass follows reset.
   a_clear: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("ready during clearing pass");

   // No result is shown right after reset.
   a_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind plate_reverb_mono_to_stereo_core prmts_check u_check (.*);

`default_nettype wire
